### rtl/core/pmgs_pkg.sv
// Shared types and constants for the player/missile graphics shifter.
package pmgs_pkg;

    localparam int NUM_PLAYERS  = 4;
    localparam int NUM_MISSILES = 4;
    localparam int PLAYER_W     = 8;
    localparam int MISSILE_W    = 2;
    localparam int NUM_POS      = 8;   // players 0-3, missiles 4-7
    localparam int NUM_GFX      = 5;   // players 0-3, missile byte 4
    localparam int GFX_MISSILE_SLOT = 4;
    localparam int VDELAY_PLAYER_BASE = 4;

    localparam logic [2:0] POS_DELAY  = 3'd5;
    localparam logic [1:0] GFX_DELAY  = 2'd3;
    localparam logic [2:0] SIZE_DELAY = 3'd5;

    typedef enum logic [2:0] {
        REQ_PIXEL        = 3'd0,
        REQ_REG_TICK     = 3'd1,
        REQ_POSITION     = 3'd2,
        REQ_GRAPHICS     = 3'd3,
        REQ_PLAYER_SIZE  = 3'd4,
        REQ_MISSILE_SIZE = 3'd5,
        REQ_PLAYER_DMA   = 3'd6,
        REQ_MISSILE_DMA  = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        CFG_PLAYER_DMA_EN  = 2'd0,
        CFG_MISSILE_DMA_EN = 2'd1,
        CFG_VDELAY         = 2'd2,
        CFG_UNUSED         = 2'd3
    } cfg_addr_t;

    typedef struct packed {
        req_t       req;
        logic [7:0] horizontal;
        logic [2:0] object_index;
        logic [7:0] data_byte;
        logic       odd_scanline;
    } item_t;

    typedef struct packed {
        logic       player_dma_enable;
        logic       missile_dma_enable;
        logic [7:0] vertical_delay;
    } cfg_t;

endpackage

### rtl/core/player_missile_graphics_shifter_core.sv
// Top level of the player/missile graphics shifter: handshake, config and objects.
//
// Four 8-bit players and four 2-bit missiles, each loaded into its shifter when
// the horizontal count on a pixel tick matches its position, then shifted out
// MSB first, each bit held for one, two or four pixel ticks as its size sets.
// Every input beat is a request: a pixel tick returns one result beat with a
// pixel mask per object; register ticks, delayed writes and DMA loads return
// nothing. Position and size writes commit after five register ticks, graphics
// writes after three. The block takes one beat per clock unless stalled: a beat
// lands in the input register, one pass of logic updates the object state, and
// a pixel tick result lands in the output register, which holds it until taken.
// The output register decouples the sides;
// input stall rises only while a pixel tick waits behind a stalled, full output.
// Configuration writes (DMA enables, vertical delay) are always ready and are
// expected only while no request is in flight.
module player_missile_graphics_shifter_core (
    input  logic       clk,
    input  logic       rst_n,
    // request channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] req_type,
    input  logic [7:0] horizontal,
    input  logic [2:0] object_index,
    input  logic [7:0] data_byte,
    input  logic       odd_scanline,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] player_pixels,
    output logic [3:0] missile_pixels,
    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    pmgs_pkg::item_t item_reg;
    logic            in_valid_reg;
    logic            out_valid_reg;
    logic [3:0]      ppix_reg, mpix_reg;
    pmgs_pkg::cfg_t  cfg_reg;

    logic            accept, advance, is_pixel, out_free, tick, op_en;
    logic [3:0]      ppix, mpix;

    logic [3:0][7:0] player_position, missile_position, player_graphics;
    logic [7:0]      missile_graphics, missile_size;
    logic [3:0][1:0] player_size;

    // Handshake: a pixel tick needs a free output slot; other requests never wait.
    always_comb
    begin
        is_pixel = (item_reg.req == pmgs_pkg::REQ_PIXEL);
        out_free = !out_valid_reg || !out_stall;
        advance  = in_valid_reg && (!is_pixel || out_free);
        in_stall = in_valid_reg && !advance;
        accept   = in_valid && !in_stall;
        tick     = advance && is_pixel;
        op_en    = advance && !is_pixel;
    end

    // Input register: load a new beat, or drop the current one once processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.req          <= pmgs_pkg::req_t'(req_type);
            item_reg.horizontal   <= horizontal;
            item_reg.object_index <= object_index;
            item_reg.data_byte    <= data_byte;
            item_reg.odd_scanline <= odd_scanline;
        end
    end

    // Configuration registers; index beyond the list is ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (pmgs_pkg::cfg_addr_t'(cfg_index))
                pmgs_pkg::CFG_PLAYER_DMA_EN:  cfg_reg.player_dma_enable  <= cfg_data[0];
                pmgs_pkg::CFG_MISSILE_DMA_EN: cfg_reg.missile_dma_enable <= cfg_data[0];
                pmgs_pkg::CFG_VDELAY:         cfg_reg.vertical_delay     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    pmgs_regs u_regs (
        .clk              (clk),
        .rst_n            (rst_n),
        .op_en            (op_en),
        .item             (item_reg),
        .cfg              (cfg_reg),
        .player_position  (player_position),
        .missile_position (missile_position),
        .player_graphics  (player_graphics),
        .missile_graphics (missile_graphics),
        .player_size      (player_size),
        .missile_size     (missile_size)
    );

    for (genvar g = 0; g < pmgs_pkg::NUM_PLAYERS; g++)
    begin : g_player
        pmgs_object #(
            .WIDTH (pmgs_pkg::PLAYER_W)
        ) u_player (
            .clk        (clk),
            .rst_n      (rst_n),
            .tick       (tick),
            .horizontal (item_reg.horizontal),
            .position   (player_position[g]),
            .graphics   (player_graphics[g]),
            .size       (player_size[g]),
            .pixel      (ppix[g])
        );
    end

    for (genvar g = 0; g < pmgs_pkg::NUM_MISSILES; g++)
    begin : g_missile
        pmgs_object #(
            .WIDTH (pmgs_pkg::MISSILE_W)
        ) u_missile (
            .clk        (clk),
            .rst_n      (rst_n),
            .tick       (tick),
            .horizontal (item_reg.horizontal),
            .position   (missile_position[g]),
            .graphics   (missile_graphics[2*g +: 2]),
            .size       (missile_size[2*g +: 2]),
            .pixel      (mpix[g])
        );
    end

    // Output register: hold a result until taken, advance on every pixel tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (tick)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            ppix_reg <= ppix;
            mpix_reg <= mpix;
        end
    end

    assign out_valid      = out_valid_reg;
    assign player_pixels  = ppix_reg;
    assign missile_pixels = mpix_reg;

endmodule

### rtl/core/pmgs_object.sv
// One graphics object: load on position match, stretch and shift out MSB first.
module pmgs_object #(
    parameter int WIDTH = pmgs_pkg::PLAYER_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tick,
    input  logic [7:0]       horizontal,
    input  logic [7:0]       position,
    input  logic [WIDTH-1:0] graphics,
    input  logic [1:0]       size,
    output logic             pixel
);

    localparam int BL_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] shift_reg, shift_next, shift_ld;
    logic [BL_W-1:0]  left_reg, left_next, left_ld;
    logic [1:0]       stretch_reg, stretch_next, stretch_ld, stretch_inc;
    logic             load, active;

    always_comb
    begin
        load       = (horizontal == position);
        shift_ld   = load ? (shift_reg | graphics) : shift_reg;
        left_ld    = load ? BL_W'(WIDTH) : left_reg;
        stretch_ld = load ? 2'd0 : stretch_reg;
        active     = (left_ld != '0);
        pixel      = active && shift_ld[WIDTH-1];
        stretch_inc  = (stretch_ld + 2'd1) & size;
        shift_next   = shift_ld;
        left_next    = left_ld;
        stretch_next = stretch_ld;
        if (active)
        begin
            stretch_next = stretch_inc;
            if (stretch_inc == 2'd0)
            begin
                shift_next = shift_ld << 1;
                left_next  = left_ld - BL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg   <= '0;
            left_reg    <= '0;
            stretch_reg <= '0;
        end
        else if (tick)
        begin
            shift_reg   <= shift_next;
            left_reg    <= left_next;
            stretch_reg <= stretch_next;
        end
    end

endmodule

### rtl/core/pmgs_regs.sv
// Object registers: delayed position, graphics and size writes, and DMA loads.
module pmgs_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  op_en,
    input  pmgs_pkg::item_t       item,
    input  pmgs_pkg::cfg_t        cfg,
    output logic [3:0][7:0]       player_position,
    output logic [3:0][7:0]       missile_position,
    output logic [3:0][7:0]       player_graphics,
    output logic [7:0]            missile_graphics,
    output logic [3:0][1:0]       player_size,
    output logic [7:0]            missile_size
);

    logic [pmgs_pkg::NUM_POS-1:0][7:0]     pos_pend_reg, pos_pend_next;
    logic [pmgs_pkg::NUM_POS-1:0][2:0]     pos_cd_reg, pos_cd_next;
    logic [pmgs_pkg::NUM_GFX-1:0][7:0]     gfx_pend_reg, gfx_pend_next;
    logic [pmgs_pkg::NUM_GFX-1:0][1:0]     gfx_cd_reg, gfx_cd_next;
    logic [pmgs_pkg::NUM_PLAYERS-1:0][1:0] psize_pend_reg, psize_pend_next;
    logic [pmgs_pkg::NUM_PLAYERS-1:0][2:0] psize_cd_reg, psize_cd_next;
    logic [7:0]                            msize_pend_reg, msize_pend_next;
    logic [2:0]                            msize_cd_reg, msize_cd_next;

    logic [pmgs_pkg::NUM_POS-1:0][7:0]     pos_reg, pos_next;
    logic [3:0][7:0]                       pgfx_reg, pgfx_next;
    logic [7:0]                            mgfx_reg, mgfx_next;
    logic [3:0][1:0]                       psize_reg, psize_next;
    logic [7:0]                            msize_reg, msize_next;

    logic [7:0] keep_mask;
    logic [1:0] pidx;

    always_comb
    begin
        pos_pend_next   = pos_pend_reg;
        pos_cd_next     = pos_cd_reg;
        gfx_pend_next   = gfx_pend_reg;
        gfx_cd_next     = gfx_cd_reg;
        psize_pend_next = psize_pend_reg;
        psize_cd_next   = psize_cd_reg;
        msize_pend_next = msize_pend_reg;
        msize_cd_next   = msize_cd_reg;
        pos_next        = pos_reg;
        pgfx_next       = pgfx_reg;
        mgfx_next       = mgfx_reg;
        psize_next      = psize_reg;
        msize_next      = msize_reg;
        pidx            = item.object_index[1:0];
        keep_mask       = '0;
        for (int i = 0; i < pmgs_pkg::NUM_MISSILES; i++)
        begin
            if (cfg.vertical_delay[i] && !item.odd_scanline)
            begin
                keep_mask[2*i +: 2] = 2'b11;
            end
        end

        if (op_en)
        begin
            unique case (item.req)
                pmgs_pkg::REQ_REG_TICK:
                begin
                    // Count down every pending write; commit at zero.
                    for (int i = 0; i < pmgs_pkg::NUM_POS; i++)
                    begin
                        if (pos_cd_reg[i] != 3'd0)
                        begin
                            pos_cd_next[i] = pos_cd_reg[i] - 3'd1;
                            if (pos_cd_reg[i] == 3'd1)
                            begin
                                pos_next[i] = pos_pend_reg[i];
                            end
                        end
                    end
                    for (int i = 0; i < pmgs_pkg::NUM_PLAYERS; i++)
                    begin
                        if (gfx_cd_reg[i] != 2'd0)
                        begin
                            gfx_cd_next[i] = gfx_cd_reg[i] - 2'd1;
                            if (gfx_cd_reg[i] == 2'd1)
                            begin
                                pgfx_next[i] = gfx_pend_reg[i];
                            end
                        end
                    end
                    if (gfx_cd_reg[pmgs_pkg::GFX_MISSILE_SLOT] != 2'd0)
                    begin
                        gfx_cd_next[pmgs_pkg::GFX_MISSILE_SLOT] =
                            gfx_cd_reg[pmgs_pkg::GFX_MISSILE_SLOT] - 2'd1;
                        if (gfx_cd_reg[pmgs_pkg::GFX_MISSILE_SLOT] == 2'd1)
                        begin
                            mgfx_next = gfx_pend_reg[pmgs_pkg::GFX_MISSILE_SLOT];
                        end
                    end
                    for (int i = 0; i < pmgs_pkg::NUM_PLAYERS; i++)
                    begin
                        if (psize_cd_reg[i] != 3'd0)
                        begin
                            psize_cd_next[i] = psize_cd_reg[i] - 3'd1;
                            if (psize_cd_reg[i] == 3'd1)
                            begin
                                psize_next[i] = psize_pend_reg[i];
                            end
                        end
                    end
                    if (msize_cd_reg != 3'd0)
                    begin
                        msize_cd_next = msize_cd_reg - 3'd1;
                        if (msize_cd_reg == 3'd1)
                        begin
                            msize_next = msize_pend_reg;
                        end
                    end
                end
                pmgs_pkg::REQ_POSITION:
                begin
                    pos_pend_next[item.object_index] = item.data_byte;
                    pos_cd_next[item.object_index]   = pmgs_pkg::POS_DELAY;
                end
                pmgs_pkg::REQ_GRAPHICS:
                begin
                    if (item.object_index < 3'(pmgs_pkg::NUM_GFX))
                    begin
                        gfx_pend_next[item.object_index] = item.data_byte;
                        gfx_cd_next[item.object_index]   = pmgs_pkg::GFX_DELAY;
                    end
                end
                pmgs_pkg::REQ_PLAYER_SIZE:
                begin
                    if (!item.object_index[2])
                    begin
                        psize_pend_next[pidx] = item.data_byte[1:0];
                        psize_cd_next[pidx]   = pmgs_pkg::SIZE_DELAY;
                    end
                end
                pmgs_pkg::REQ_MISSILE_SIZE:
                begin
                    msize_pend_next = item.data_byte;
                    msize_cd_next   = pmgs_pkg::SIZE_DELAY;
                end
                pmgs_pkg::REQ_PLAYER_DMA:
                begin
                    if (!item.object_index[2] && cfg.player_dma_enable &&
                        !(cfg.vertical_delay[pmgs_pkg::VDELAY_PLAYER_BASE + 32'(pidx)] &&
                          !item.odd_scanline))
                    begin
                        pgfx_next[pidx] = item.data_byte;
                    end
                end
                pmgs_pkg::REQ_MISSILE_DMA:
                begin
                    // Delayed missiles keep their pair on even lines.
                    if (cfg.missile_dma_enable)
                    begin
                        mgfx_next = (mgfx_reg & keep_mask) | (item.data_byte & ~keep_mask);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_pend_reg   <= '0;
            pos_cd_reg     <= '0;
            gfx_pend_reg   <= '0;
            gfx_cd_reg     <= '0;
            psize_pend_reg <= '0;
            psize_cd_reg   <= '0;
            msize_pend_reg <= '0;
            msize_cd_reg   <= '0;
            pos_reg        <= '0;
            pgfx_reg       <= '0;
            mgfx_reg       <= '0;
            psize_reg      <= '0;
            msize_reg      <= '0;
        end
        else
        begin
            pos_pend_reg   <= pos_pend_next;
            pos_cd_reg     <= pos_cd_next;
            gfx_pend_reg   <= gfx_pend_next;
            gfx_cd_reg     <= gfx_cd_next;
            psize_pend_reg <= psize_pend_next;
            psize_cd_reg   <= psize_cd_next;
            msize_pend_reg <= msize_pend_next;
            msize_cd_reg   <= msize_cd_next;
            pos_reg        <= pos_next;
            pgfx_reg       <= pgfx_next;
            mgfx_reg       <= mgfx_next;
            psize_reg      <= psize_next;
            msize_reg      <= msize_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < pmgs_pkg::NUM_PLAYERS; i++)
        begin
            player_position[i]  = pos_reg[i];
            missile_position[i] = pos_reg[pmgs_pkg::NUM_PLAYERS + i];
        end
        player_graphics  = pgfx_reg;
        missile_graphics = mgfx_reg;
        player_size      = psize_reg;
        missile_size     = msize_reg;
    end

endmodule

### bench/pmgs_pixel_checker.sv
// Pixel mask checker: mirrors the object shifters and compares each result beat.
module pmgs_pixel_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [2:0] req_type,
    input  logic [7:0] horizontal,
    input  logic [2:0] object_index,
    input  logic [7:0] data_byte,
    input  logic       odd_scanline,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [3:0] player_pixels,
    input  logic [3:0] missile_pixels,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         mismatches,
    output int         masks_waiting
);

    typedef struct packed {
        logic [3:0] players;
        logic [3:0] missiles;
    } pixel_mask_t;

    pmgs_pkg::cfg_t cfg;
    pixel_mask_t    expected_masks[$];
    int             fail_count = 0;

    logic [7:0] pl_gfx     [pmgs_pkg::NUM_PLAYERS];
    logic [7:0] pl_pos     [pmgs_pkg::NUM_PLAYERS];
    logic [7:0] pl_shift   [pmgs_pkg::NUM_PLAYERS];
    logic [3:0] pl_left    [pmgs_pkg::NUM_PLAYERS];
    logic [1:0] pl_stretch [pmgs_pkg::NUM_PLAYERS];
    logic [1:0] pl_size    [pmgs_pkg::NUM_PLAYERS];
    logic [7:0] ms_gfx;
    logic [7:0] ms_size;
    logic [7:0] ms_pos     [pmgs_pkg::NUM_MISSILES];
    logic [1:0] ms_shift   [pmgs_pkg::NUM_MISSILES];
    logic [1:0] ms_left    [pmgs_pkg::NUM_MISSILES];
    logic [1:0] ms_stretch [pmgs_pkg::NUM_MISSILES];
    logic [7:0] pend_pos   [pmgs_pkg::NUM_POS];
    logic [2:0] pos_cd     [pmgs_pkg::NUM_POS];
    logic [7:0] pend_gfx   [pmgs_pkg::NUM_GFX];
    logic [1:0] gfx_cd     [pmgs_pkg::NUM_GFX];
    logic [1:0] pend_psize [pmgs_pkg::NUM_PLAYERS];
    logic [2:0] psize_cd   [pmgs_pkg::NUM_PLAYERS];
    logic [7:0] pend_msize;
    logic [2:0] msize_cd;

    assign mismatches = fail_count;

    // Advance the object state by one request; queue a mask for a pixel tick.
    function automatic void predict_request(pmgs_pkg::req_t kind, logic [7:0] h,
                                            logic [2:0] idx, logic [7:0] data, logic odd);
        pixel_mask_t m;
        logic [1:0]  sz;
        logic [7:0]  keep;
        logic [1:0]  pidx;
        m = '0;
        keep = 8'h00;
        pidx = idx[1:0];
        case (kind)
            pmgs_pkg::REQ_PIXEL:
            begin
                for (int i = 0; i < pmgs_pkg::NUM_PLAYERS; i++)
                begin
                    if (h == pl_pos[i])
                    begin
                        pl_shift[i]   = pl_shift[i] | pl_gfx[i];
                        pl_left[i]    = 4'd8;
                        pl_stretch[i] = 2'd0;
                    end
                    m.players[i] = (pl_left[i] != 0) && pl_shift[i][7];
                    if (pl_left[i] != 0)
                    begin
                        pl_stretch[i] = (pl_stretch[i] + 2'd1) & pl_size[i];
                        if (pl_stretch[i] == 0)
                        begin
                            pl_shift[i] = pl_shift[i] << 1;
                            pl_left[i]  = pl_left[i] - 4'd1;
                        end
                    end
                end
                for (int i = 0; i < pmgs_pkg::NUM_MISSILES; i++)
                begin
                    sz = ms_size[2*i +: 2];
                    if (h == ms_pos[i])
                    begin
                        ms_shift[i]   = ms_shift[i] | ms_gfx[2*i +: 2];
                        ms_left[i]    = 2'd2;
                        ms_stretch[i] = 2'd0;
                    end
                    m.missiles[i] = (ms_left[i] != 0) && ms_shift[i][1];
                    if (ms_left[i] != 0)
                    begin
                        ms_stretch[i] = (ms_stretch[i] + 2'd1) & sz;
                        if (ms_stretch[i] == 0)
                        begin
                            ms_shift[i] = {ms_shift[i][0], 1'b0};
                            ms_left[i]  = ms_left[i] - 2'd1;
                        end
                    end
                end
                expected_masks.push_back(m);
            end
            pmgs_pkg::REQ_REG_TICK:
            begin
                for (int i = 0; i < pmgs_pkg::NUM_POS; i++)
                begin
                    if (pos_cd[i] != 0)
                    begin
                        pos_cd[i] = pos_cd[i] - 3'd1;
                        if (pos_cd[i] == 0)
                        begin
                            if (i < pmgs_pkg::NUM_PLAYERS)
                                pl_pos[i] = pend_pos[i];
                            else
                                ms_pos[i - pmgs_pkg::NUM_PLAYERS] = pend_pos[i];
                        end
                    end
                end
                for (int i = 0; i < pmgs_pkg::NUM_GFX; i++)
                begin
                    if (gfx_cd[i] != 0)
                    begin
                        gfx_cd[i] = gfx_cd[i] - 2'd1;
                        if (gfx_cd[i] == 0)
                        begin
                            if (i == pmgs_pkg::GFX_MISSILE_SLOT)
                                ms_gfx = pend_gfx[i];
                            else
                                pl_gfx[i] = pend_gfx[i];
                        end
                    end
                end
                for (int i = 0; i < pmgs_pkg::NUM_PLAYERS; i++)
                begin
                    if (psize_cd[i] != 0)
                    begin
                        psize_cd[i] = psize_cd[i] - 3'd1;
                        if (psize_cd[i] == 0)
                            pl_size[i] = pend_psize[i];
                    end
                end
                if (msize_cd != 0)
                begin
                    msize_cd = msize_cd - 3'd1;
                    if (msize_cd == 0)
                        ms_size = pend_msize;
                end
            end
            pmgs_pkg::REQ_POSITION:
            begin
                pend_pos[idx] = data;
                pos_cd[idx]   = pmgs_pkg::POS_DELAY;
            end
            pmgs_pkg::REQ_GRAPHICS:
            begin
                if (idx < pmgs_pkg::NUM_GFX)
                begin
                    pend_gfx[idx] = data;
                    gfx_cd[idx]   = pmgs_pkg::GFX_DELAY;
                end
            end
            pmgs_pkg::REQ_PLAYER_SIZE:
            begin
                if (idx < pmgs_pkg::NUM_PLAYERS)
                begin
                    pend_psize[pidx] = data[1:0];
                    psize_cd[pidx]   = pmgs_pkg::SIZE_DELAY;
                end
            end
            pmgs_pkg::REQ_MISSILE_SIZE:
            begin
                pend_msize = data;
                msize_cd   = pmgs_pkg::SIZE_DELAY;
            end
            pmgs_pkg::REQ_PLAYER_DMA:
            begin
                if (idx < pmgs_pkg::NUM_PLAYERS && cfg.player_dma_enable)
                begin
                    if (!(cfg.vertical_delay[pmgs_pkg::VDELAY_PLAYER_BASE + pidx] && !odd))
                        pl_gfx[pidx] = data;
                end
            end
            pmgs_pkg::REQ_MISSILE_DMA:
            begin
                if (cfg.missile_dma_enable)
                begin
                    // delayed missiles hold their bit pair on even lines
                    for (int i = 0; i < pmgs_pkg::NUM_MISSILES; i++)
                        if (cfg.vertical_delay[i] && !odd)
                            keep[2*i +: 2] = 2'b11;
                    ms_gfx = (ms_gfx & keep) | (data & ~keep);
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg        = '0;
            ms_gfx     = '0;
            ms_size    = '0;
            pend_msize = '0;
            msize_cd   = '0;
            for (int i = 0; i < pmgs_pkg::NUM_PLAYERS; i++)
            begin
                pl_gfx[i]     = '0;
                pl_pos[i]     = '0;
                pl_shift[i]   = '0;
                pl_left[i]    = '0;
                pl_stretch[i] = '0;
                pl_size[i]    = '0;
                pend_psize[i] = '0;
                psize_cd[i]   = '0;
                ms_pos[i]     = '0;
                ms_shift[i]   = '0;
                ms_left[i]    = '0;
                ms_stretch[i] = '0;
            end
            for (int i = 0; i < pmgs_pkg::NUM_POS; i++)
            begin
                pend_pos[i] = '0;
                pos_cd[i]   = '0;
            end
            for (int i = 0; i < pmgs_pkg::NUM_GFX; i++)
            begin
                pend_gfx[i] = '0;
                gfx_cd[i]   = '0;
            end
            expected_masks.delete();
            masks_waiting <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_masks.size() == 0)
                begin
                    $error("result beat with no pixel tick waiting: players %h missiles %h",
                           player_pixels, missile_pixels);
                    fail_count++;
                end
                else
                begin
                    pixel_mask_t exp_m;
                    exp_m = expected_masks.pop_front();
                    if (player_pixels !== exp_m.players)
                    begin
                        $error("player_pixels: expected %h, actual %h",
                               exp_m.players, player_pixels);
                        fail_count++;
                    end
                    if (missile_pixels !== exp_m.missiles)
                    begin
                        $error("missile_pixels: expected %h, actual %h",
                               exp_m.missiles, missile_pixels);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (pmgs_pkg::cfg_addr_t'(cfg_index))
                    pmgs_pkg::CFG_PLAYER_DMA_EN:  cfg.player_dma_enable  = cfg_data[0];
                    pmgs_pkg::CFG_MISSILE_DMA_EN: cfg.missile_dma_enable = cfg_data[0];
                    pmgs_pkg::CFG_VDELAY:         cfg.vertical_delay     = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_request(pmgs_pkg::req_t'(req_type), horizontal, object_index,
                                data_byte, odd_scanline);
            masks_waiting <= expected_masks.size();
        end
    end

endmodule

### bench/tb_player_missile_graphics_shifter_core.sv
// Testbench top: stimulus, receiver stalls, watchdog and verdict for the shifter core.
module tb_player_missile_graphics_shifter_core;

    // Timing knobs: drain covers the in-flight result plus margin for request
    // beats that make no result; the watchdog trips on a long run of dead cycles.
    localparam int DRAIN_CYCLES   = 6;
    localparam int LONG_HOLD      = 64;
    localparam int PHASE_BEATS    = 130;
    localparam int WATCHDOG_LIMIT = 1000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] req_type;
    logic [7:0] horizontal;
    logic [2:0] object_index;
    logic [7:0] data_byte;
    logic       odd_scanline;
    logic       out_valid;
    logic       out_stall;
    logic [3:0] player_pixels;
    logic [3:0] missile_pixels;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    int   mismatches;
    int   masks_waiting;

    // Knobs and counters for the stimulus, the receiver and the watchdog.
    bit   tx_idle_en;
    bit   rx_idle_en;
    int   holds_asked;
    int   holds_served = 0;
    int   beats_sent;
    int   dead_cycles = 0;
    logic [7:0] beam_start;

    always #2 clk = ~clk;

    player_missile_graphics_shifter_core u_dut (.*);

    pmgs_pixel_checker u_checker (.*);

    // Watchdog: count cycles in which no channel moves a beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                dead_cycles <= 0;
            else if (dead_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                dead_cycles <= dead_cycles + 1;
        end
    end

    // Receiver: random stall bursts, quiet stretches, and a long hold-off on
    // request, counted here so the sender can keep pushing.
    initial
    begin : result_sink
        int burst;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_asked)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
                holds_served++;
            end
            else if (rx_idle_en && $urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(1, 18);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 39) == 0)
            begin
                // hold the stall low for a while
                out_stall <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Offer one request beat and return at the edge that takes it. Valid is
    // left high so back-to-back beats need no second assignment in one step.
    task automatic send_beat(input pmgs_pkg::req_t kind, input logic [7:0] h,
                             input logic [2:0] idx, input logic [7:0] data, input logic odd);
        int gap;
        if (tx_idle_en && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= kind;
        horizontal   <= h;
        object_index <= idx;
        data_byte    <= data;
        odd_scanline <= odd;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
    endtask

    // Drop valid and wait out every pending mask, then the in-flight tail.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (masks_waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all three registers back to back; upper enable bits are junk.
    task automatic load_settings(input logic pdma, input logic mdma, input logic [7:0] vd);
        cfg_valid <= 1'b1;
        cfg_index <= pmgs_pkg::CFG_PLAYER_DMA_EN;
        cfg_data  <= {7'($urandom), pdma};
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= pmgs_pkg::CFG_MISSILE_DMA_EN;
        cfg_data  <= {7'($urandom), mdma};
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= pmgs_pkg::CFG_VDELAY;
        cfg_data  <= vd;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One scanline: a few delayed writes, register ticks, DMA loads, then a
    // run of pixel ticks. Positions mostly land inside the run so objects
    // actually get loaded and shifted out.
    task automatic run_scanline();
        logic [7:0] start;
        logic       odd;
        int         writes;
        int         run_len;
        odd = 1'($urandom);
        start = ($urandom_range(0, 3) == 0) ? 8'($urandom) : beam_start;
        writes = $urandom_range(1, 4);
        for (int k = 0; k < writes; k++)
        begin
            case ($urandom_range(0, 3))
                0: send_beat(pmgs_pkg::REQ_POSITION, 8'($urandom), 3'($urandom),
                             ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                 : beam_start + 8'($urandom_range(0, 30)), odd);
                1: send_beat(pmgs_pkg::REQ_GRAPHICS, 8'($urandom),
                             3'($urandom_range(0, 5)), 8'($urandom), odd);
                2: send_beat(pmgs_pkg::REQ_PLAYER_SIZE, 8'($urandom),
                             3'($urandom_range(0, 4)), 8'($urandom), odd);
                default: send_beat(pmgs_pkg::REQ_MISSILE_SIZE, 8'($urandom), 3'($urandom),
                                   8'($urandom), odd);
            endcase
        end
        repeat ($urandom_range(0, 6))
            send_beat(pmgs_pkg::REQ_REG_TICK, 8'($urandom), 3'($urandom), 8'($urandom), odd);
        if ($urandom_range(0, 1) == 1)
            send_beat(pmgs_pkg::REQ_PLAYER_DMA, 8'($urandom), 3'($urandom_range(0, 4)),
                      8'($urandom), odd);
        if ($urandom_range(0, 1) == 1)
            send_beat(pmgs_pkg::REQ_MISSILE_DMA, 8'($urandom), 3'($urandom),
                      8'($urandom), odd);
        run_len = $urandom_range(12, 40);
        for (int k = 0; k < run_len; k++)
            send_beat(pmgs_pkg::REQ_PIXEL, start + 8'(k), 3'($urandom), 8'($urandom), odd);
    endtask

    // Mostly scanlines; now and then a burst of fully random beats as noise.
    task automatic run_random(input int count);
        int target;
        target = beats_sent + count;
        beam_start = 8'($urandom);
        while (beats_sent < target)
        begin
            if ($urandom_range(0, 9) < 8)
                run_scanline();
            else
                repeat ($urandom_range(2, 6))
                    send_beat(pmgs_pkg::req_t'($urandom_range(0, 7)), 8'($urandom),
                              3'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin : stimulus
        rst_n        = 1'b0;
        in_valid     <= 1'b0;
        req_type     <= pmgs_pkg::REQ_PIXEL;
        horizontal   <= 8'd0;
        object_index <= 3'd0;
        data_byte    <= 8'd0;
        odd_scanline <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= pmgs_pkg::CFG_PLAYER_DMA_EN;
        cfg_data     <= 8'd0;
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
        holds_asked  = 0;
        beats_sent   = 0;
        beam_start   = 8'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: players 1 and 3 delayed (bit 5, bit 7), missiles 0 and 2 delayed.
        load_settings(1'b1, 1'b1, 8'hA5);
        // Rewrite a pending position: the second write replaces the first.
        send_beat(pmgs_pkg::REQ_POSITION, 8'h00, 3'd0, 8'h33, 1'b0);
        send_beat(pmgs_pkg::REQ_POSITION, 8'hFF, 3'd0, 8'd10, 1'b1);
        send_beat(pmgs_pkg::REQ_POSITION, 8'h5A, 3'd7, 8'hFF, 1'b0);
        send_beat(pmgs_pkg::REQ_GRAPHICS, 8'h00, 3'd0, 8'hFF, 1'b0);
        send_beat(pmgs_pkg::REQ_GRAPHICS, 8'h00, 3'd4, 8'hE4, 1'b0);
        // Out-of-range indices drop the write.
        send_beat(pmgs_pkg::REQ_GRAPHICS, 8'h00, 3'd7, 8'h55, 1'b0);
        send_beat(pmgs_pkg::REQ_PLAYER_SIZE, 8'h00, 3'd6, 8'h03, 1'b0);
        // Only the low two bits of a player size stick: size 1 here.
        send_beat(pmgs_pkg::REQ_PLAYER_SIZE, 8'h00, 3'd0, 8'hFD, 1'b0);
        // Missile size ignores the index.
        send_beat(pmgs_pkg::REQ_MISSILE_SIZE, 8'h00, 3'd5, 8'hFF, 1'b0);
        repeat (5)
            send_beat(pmgs_pkg::REQ_REG_TICK, 8'h00, 3'd0, 8'h00, 1'b0);
        // Player 1 is delayed: the even-line load is dropped. Index 5 is ignored.
        send_beat(pmgs_pkg::REQ_PLAYER_DMA, 8'h00, 3'd1, 8'h81, 1'b0);
        send_beat(pmgs_pkg::REQ_PLAYER_DMA, 8'h00, 3'd5, 8'hFF, 1'b1);
        // Even line: delayed missiles 0 and 2 keep their old bit pairs.
        send_beat(pmgs_pkg::REQ_MISSILE_DMA, 8'h00, 3'd6, 8'hFF, 1'b0);
        send_beat(pmgs_pkg::REQ_PIXEL, 8'h00, 3'd0, 8'h00, 1'b0);
        for (int k = 10; k < 14; k++)
            send_beat(pmgs_pkg::REQ_PIXEL, 8'(k), 3'd0, 8'h00, 1'b0);
        // Reload while still shifting: graphics OR into the bits left.
        send_beat(pmgs_pkg::REQ_PIXEL, 8'd10, 3'd0, 8'h00, 1'b0);
        send_beat(pmgs_pkg::REQ_PIXEL, 8'hFF, 3'd7, 8'hFF, 1'b1);
        settle();

        load_settings(1'b0, 1'b0, 8'h00);
        run_random(PHASE_BEATS);
        settle();

        // Long receiver hold-off while pixel ticks keep coming: the output
        // register fills and the input stall has to rise.
        load_settings(1'b1, 1'b1, 8'hFF);
        tx_idle_en = 1'b0;
        holds_asked++;
        for (int k = 0; k < 40; k++)
            send_beat(pmgs_pkg::REQ_PIXEL, 8'(k), 3'($urandom), 8'($urandom), 1'($urandom));
        tx_idle_en = 1'b1;
        run_random(PHASE_BEATS);
        settle();

        load_settings(1'b1, 1'b0, 8'h0F);
        run_random(PHASE_BEATS);
        settle();

        load_settings(1'b0, 1'b1, 8'hF0);
        run_random(PHASE_BEATS);
        settle();

        // Last stretch runs flat out on both sides.
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        load_settings(1'b1, 1'b1, 8'($urandom));
        run_random(PHASE_BEATS);
        settle();

        if (mismatches == 0 && masks_waiting == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
rtl/core/pmgs_pkg.sv
rtl/core/pmgs_object.sv
rtl/core/pmgs_regs.sv
rtl/core/player_missile_graphics_shifter_core.sv
bench/pmgs_pixel_checker.sv
bench/tb_player_missile_graphics_shifter_core.sv
